/* hdl/fmma_pkg.sv */
// Shared constants for the frame mean / max / argmax block.
package fmma_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int CFG_DIM_W   = 13;
  localparam int OUT_POS_W   = 12;
  localparam int DEF_MAX_DIM = 4096;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int QUEUE_DEPTH = 2;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_index_t;

endpackage

/* hdl/fmma_regs.sv */
// Configuration registers: APB access, dimension clamping, element count.
module fmma_regs #(
  parameter int MAX_DIM = fmma_pkg::DEF_MAX_DIM
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [fmma_pkg::PADDR_W-1:0]                  paddr,
  input  logic [fmma_pkg::PDATA_W-1:0]                  pwdata,
  output logic [fmma_pkg::PDATA_W-1:0]                  prdata,
  output logic                                          pready,
  output logic                                          frame_clear,
  output logic [$clog2(MAX_DIM+1)-1:0]                  rows_eff,
  output logic [$clog2(MAX_DIM+1)-1:0]                  cols_eff,
  output logic [2*$clog2(MAX_DIM+1)-1:0]                elem_count
);
  import fmma_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM+1);
  localparam int CNT_W = 2*DIM_W;
  localparam int EXT_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;

  logic [CFG_DIM_W-1:0] row_count_r;
  logic [CFG_DIM_W-1:0] col_count_r;
  logic [CNT_W-1:0]     elem_count_r;
  logic                 wr_en;
  reg_index_t           wr_idx;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > EXT_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(ext);
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_DIM_W'(1);
      col_count_r <= CFG_DIM_W'(1);
    end else if (wr_en) begin
      case (wr_idx)
        REG_ROW_COUNT: row_count_r <= pwdata[CFG_DIM_W-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_ROW_COUNT: prdata = PDATA_W'(row_count_r);
      REG_COL_COUNT: prdata = PDATA_W'(col_count_r);
      default:       prdata = '0;
    endcase
  end

  assign rows_eff = clamp_dim(row_count_r);
  assign cols_eff = clamp_dim(col_count_r);

  // divisor for the mean; stable long before a frame reaches the divider
  always_ff @(posedge clk) begin
    elem_count_r <= rows_eff * cols_eff;
  end

  assign elem_count  = elem_count_r;
  assign frame_clear = wr_en;

endmodule

/* hdl/fmma_front.sv */
// Front part: takes samples, keeps running sum, maximum and its position.
module fmma_front #(
  parameter int MAX_DIM = fmma_pkg::DEF_MAX_DIM
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  frame_clear,
  input  logic [$clog2(MAX_DIM+1)-1:0]          rows_eff,
  input  logic [$clog2(MAX_DIM+1)-1:0]          cols_eff,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fmma_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [2*fmma_pkg::SAMPLE_W+4*$clog2(MAX_DIM)-1:0] q_wdata
);
  import fmma_pkg::*;

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM+1);
  localparam int SUM_W = SAMPLE_W + 2*POS_W;

  logic [SUM_W-1:0]           sum_r;
  logic signed [SAMPLE_W-1:0] best_r;
  logic [POS_W-1:0]           best_row_r;
  logic [POS_W-1:0]           best_col_r;
  logic [POS_W-1:0]           row_pos_r;
  logic [POS_W-1:0]           col_pos_r;

  logic [SUM_W-1:0]           sum_nxt;
  logic signed [SAMPLE_W-1:0] best_nxt;
  logic [POS_W-1:0]           best_row_nxt;
  logic [POS_W-1:0]           best_col_nxt;
  logic                       take;
  logic                       greater;
  logic                       last_col;
  logic                       last_row;
  logic [DIM_W-1:0]           col_inc;
  logic [DIM_W-1:0]           row_inc;

  assign in_ready = ~q_full;
  assign take     = in_valid & in_ready;

  assign sum_nxt      = sum_r + {{(SUM_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
  assign greater      = in_sample > best_r;
  assign best_nxt     = greater ? in_sample : best_r;
  assign best_row_nxt = greater ? row_pos_r : best_row_r;
  assign best_col_nxt = greater ? col_pos_r : best_col_r;

  assign col_inc  = DIM_W'(col_pos_r) + DIM_W'(1);
  assign row_inc  = DIM_W'(row_pos_r) + DIM_W'(1);
  assign last_col = col_inc >= cols_eff;
  assign last_row = row_inc >= rows_eff;

  assign q_push  = take & last_col & last_row;
  assign q_wdata = {sum_nxt, best_nxt, best_row_nxt, best_col_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || frame_clear || q_push) begin
      sum_r      <= '0;
      best_r     <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      best_row_r <= '0;
      best_col_r <= '0;
      row_pos_r  <= '0;
      col_pos_r  <= '0;
    end else if (take) begin
      sum_r      <= sum_nxt;
      best_r     <= best_nxt;
      best_row_r <= best_row_nxt;
      best_col_r <= best_col_nxt;
      if (!last_col) begin
        col_pos_r <= col_inc[POS_W-1:0];
      end else begin
        col_pos_r <= '0;
        row_pos_r <= row_inc[POS_W-1:0];
      end
    end
  end

endmodule

/* hdl/fmma_queue.sv */
// Short queue of finished frame statistics between front and back.
module fmma_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);
  import fmma_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH+1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  assign full  = fill_r == FILL_W'(QUEUE_DEPTH);
  assign empty = fill_r == '0;
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill_r <= fill_r + FILL_W'(1);
        2'b01:   fill_r <= fill_r - FILL_W'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

/* hdl/fmma_back.sv */
// Back part: bit-serial signed mean division and the result register.
module fmma_back #(
  parameter int MAX_DIM = fmma_pkg::DEF_MAX_DIM
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [2*$clog2(MAX_DIM+1)-1:0]         elem_count,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  logic [2*fmma_pkg::SAMPLE_W+4*$clog2(MAX_DIM)-1:0] q_rdata,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fmma_pkg::SAMPLE_W-1:0]   out_mean_value,
  output logic signed [fmma_pkg::SAMPLE_W-1:0]   out_max_value,
  output logic [fmma_pkg::OUT_POS_W-1:0]         out_max_row,
  output logic [fmma_pkg::OUT_POS_W-1:0]         out_max_col
);
  import fmma_pkg::*;

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM+1);
  localparam int CNT_W  = 2*DIM_W;
  localparam int SUM_W  = SAMPLE_W + 2*POS_W;
  localparam int ITER_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t           state_r;
  back_state_t           state_nxt;
  logic [SUM_W-1:0]      quo_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      div_r;
  logic                  neg_r;
  logic [ITER_W-1:0]     iter_r;
  logic [SAMPLE_W-1:0]   max_r;
  logic [POS_W-1:0]      row_r;
  logic [POS_W-1:0]      col_r;

  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_mean_r;
  logic [SAMPLE_W-1:0]   out_max_r;
  logic [OUT_POS_W-1:0]  out_row_r;
  logic [OUT_POS_W-1:0]  out_col_r;

  logic [SUM_W-1:0]      q_sum;
  logic [SUM_W-1:0]      q_mag;
  logic [CNT_W:0]        shifted;
  logic [CNT_W:0]        diff;
  logic                  fits;
  logic [CNT_W-1:0]      rem_nxt;
  logic [SAMPLE_W-1:0]   mean_mag;
  logic [SAMPLE_W-1:0]   mean_val;
  logic                  load_out;

  assign q_sum = q_rdata[2*POS_W+SAMPLE_W +: SUM_W];
  assign q_mag = q_sum[SUM_W-1] ? (~q_sum + SUM_W'(1)) : q_sum;

  // restoring step: one quotient bit per cycle, dividend shifted in MSB first
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign fits    = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};
  assign rem_nxt = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];

  assign mean_mag = quo_r[SAMPLE_W-1:0];
  assign mean_val = neg_r ? (~mean_mag + SAMPLE_W'(1)) : mean_mag;

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_DIV;
      ST_DIV:  if (iter_r == '0) state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo_r  <= q_mag;
      rem_r  <= '0;
      div_r  <= elem_count;
      neg_r  <= q_sum[SUM_W-1];
      iter_r <= ITER_W'(SUM_W-1);
      max_r  <= q_rdata[2*POS_W +: SAMPLE_W];
      row_r  <= q_rdata[POS_W +: POS_W];
      col_r  <= q_rdata[0 +: POS_W];
    end else if (state_r == ST_DIV) begin
      quo_r  <= {quo_r[SUM_W-2:0], fits};
      rem_r  <= rem_nxt;
      iter_r <= iter_r - ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_r <= mean_val;
      out_max_r  <= max_r;
      out_row_r  <= OUT_POS_W'(row_r);
      out_col_r  <= OUT_POS_W'(col_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_max_value  = out_max_r;
  assign out_max_row    = out_row_r;
  assign out_max_col    = out_col_r;

endmodule

/* hdl/frame_mean_max_argmax.sv */
// Frame statistics: streaming mean, maximum and position of the maximum.
//
// Samples of a rows x columns frame arrive in row-major order on the input
// channel (in_valid/in_ready/in_sample), one beat per cycle while in_ready
// is high. The last sample of a frame yields one result beat on the output
// channel: truncated mean, maximum and the row/column where it first appears.
// Row and column counts sit in two APB registers at byte addresses 0 and 4;
// zero counts as one, values above MAX_DIM as MAX_DIM. Any write restarts the
// frame in progress; write only while the block is idle.
//
// Throughput: one sample per cycle while in_ready is high. The mean comes
// from a restoring divider that yields one quotient bit per cycle.
// A two-entry queue holds finished frames ahead of the divider; in_ready
// drops only while that queue is full, which can happen with frames shorter
// than the divider time or while the output is stalled.
// A stalled receiver holds the result register; the divider finishes the
// frame it has, then waits until the result register frees up.
// Reset (rst_n low, synchronous) sets both counts to 1 and clears the frame
// accumulators, queue pointers, divider state and out_valid; data registers
// in the queue and the back part are not reset.
module frame_mean_max_argmax #(
  parameter int MAX_DIM = fmma_pkg::DEF_MAX_DIM
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fmma_pkg::PADDR_W-1:0]          paddr,
  input  logic [fmma_pkg::PDATA_W-1:0]          pwdata,
  output logic [fmma_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fmma_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fmma_pkg::SAMPLE_W-1:0]  out_mean_value,
  output logic signed [fmma_pkg::SAMPLE_W-1:0]  out_max_value,
  output logic [fmma_pkg::OUT_POS_W-1:0]        out_max_row,
  output logic [fmma_pkg::OUT_POS_W-1:0]        out_max_col
);
  import fmma_pkg::*;

  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM+1);
  localparam int CNT_W   = 2*DIM_W;
  // running sum, maximum, row, column
  localparam int ENTRY_W = 2*SAMPLE_W + 4*POS_W;

  logic               frame_clear;
  logic [DIM_W-1:0]   rows_eff;
  logic [DIM_W-1:0]   cols_eff;
  logic [CNT_W-1:0]   elem_count;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  fmma_regs #(.MAX_DIM(MAX_DIM)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .frame_clear (frame_clear),
    .rows_eff    (rows_eff),
    .cols_eff    (cols_eff),
    .elem_count  (elem_count)
  );

  fmma_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_clear (frame_clear),
    .rows_eff    (rows_eff),
    .cols_eff    (cols_eff),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  fmma_queue #(.DATA_W(ENTRY_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  fmma_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .elem_count     (elem_count),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_rdata        (q_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean_value (out_mean_value),
    .out_max_value  (out_max_value),
    .out_max_row    (out_max_row),
    .out_max_col    (out_max_col)
  );

endmodule

/* hdl/fmma_checker.sv */
// Port-level checks for the frame statistics block, bound to its top level.
module fmma_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  pready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [fmma_pkg::SAMPLE_W-1:0]  out_mean_value,
  input logic signed [fmma_pkg::SAMPLE_W-1:0]  out_max_value,
  input logic [fmma_pkg::OUT_POS_W-1:0]        out_max_row,
  input logic [fmma_pkg::OUT_POS_W-1:0]        out_max_col
);

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

  // a truncated mean never exceeds the frame maximum
  a_mean_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mean_value <= out_max_value))
    else $error("mean above maximum");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_value) &&
      $stable(out_max_value) && $stable(out_max_row) && $stable(out_max_col))
    else $error("stalled result beat changed");

endmodule

bind frame_mean_max_argmax fmma_checker u_fmma_checker (.*);
